### rtl/core/ssu_pkg.sv
// Shared types, constants and a helper function of the sequence residue sanitizer.
// Used by the channel interfaces, the datapath modules and the checker.
`default_nettype none

package ssu_pkg;

  localparam int unsigned MAX_RECORD_LEN = 1048576;
  localparam int unsigned CountW         = 21;
  localparam int unsigned CharW          = 8;
  localparam int unsigned CfgIdxW        = 8;
  localparam int unsigned CfgDataW       = 32;

  localparam logic [CfgIdxW-1:0] REG_MOLECULE   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH = 8'd1;

  typedef enum logic [1:0] {
    MOL_PROTEIN = 2'd0,
    MOL_DNA     = 2'd1,
    MOL_RRNA    = 2'd2,
    MOL_UNKNOWN = 2'd3
  } mol_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALF_AMBIG  = 3'd1,
    ST_MANY_REPL   = 3'd2,
    ST_MOSTLY_AMBIG = 3'd3,
    ST_BAD_CHAR    = 3'd4,
    ST_BAD_MOL     = 3'd5,
    ST_TOO_SHORT   = 3'd6
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] clean_char;
    logic             is_ambig;
    logic             is_repl;
    logic             is_bad;
  } ssu_class_t;

  typedef struct packed {
    logic [CharW-1:0]  clean_char;
    logic              record_end;
    status_e           record_status;
    logic [CountW-1:0] ambiguous_count;
    logic [CountW-1:0] replaced_count;
    logic [CountW-1:0] record_length;
  } ssu_result_t;

  // IUPAC code to representative base, zero for N and for any byte that is no mapped IUPAC code
  function automatic logic [CharW-1:0] iupac_base(input logic [CharW-1:0] c);
    logic [CharW-1:0] b;
    b = '0;
    case (c)
      "R", "W", "M", "D", "H", "V": b = "A";
      "Y", "B":                     b = "C";
      "S", "K":                     b = "G";
      default:                      b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ssu_if.sv
// Valid/ready channel interfaces of the sequence residue sanitizer.
// Depends on ssu_pkg for field widths.
`default_nettype none

interface ssu_in_if import ssu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] seq_char;
  logic             last_char;
  modport source(output valid, seq_char, last_char, input ready);
  modport sink(input valid, seq_char, last_char, output ready);
endinterface

interface ssu_out_if import ssu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CharW-1:0]  clean_char;
  logic              record_end;
  logic [2:0]        record_status;
  logic [CountW-1:0] ambiguous_count;
  logic [CountW-1:0] replaced_count;
  logic [CountW-1:0] record_length;
  modport source(output valid, clean_char, record_end, record_status, ambiguous_count,
                 replaced_count, record_length, input ready);
  modport sink(input valid, clean_char, record_end, record_status, ambiguous_count,
               replaced_count, record_length, output ready);
endinterface

interface ssu_cfg_if import ssu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/ssu_classify.sv
// Per-character classification: upper-casing, alphabet check, ambiguity and IUPAC map.
// Depends on ssu_pkg.
`default_nettype none

module ssu_classify import ssu_pkg::*; (
  input  logic [CharW-1:0] char_i,
  input  mol_e             mol_i,
  output ssu_class_t       cls_o
);

  logic [CharW-1:0] up;
  logic [CharW-1:0] base;
  logic             prot_ok;
  logic             nucl_ok;
  logic             ambig;

  always_comb begin
    up      = (char_i inside {["a":"z"]}) ? char_i - 8'd32 : char_i;
    base    = iupac_base(up);
    prot_ok = up inside {["A":"I"], ["K":"N"], ["P":"Z"], ".", "-", "*"};
    nucl_ok = up inside {"-", "A", "C", "G", "T", "U", "."};
    ambig   = (up == "X") || (up == "N");

    cls_o.clean_char = up;
    cls_o.is_ambig   = 1'b0;
    cls_o.is_repl    = 1'b0;
    cls_o.is_bad     = 1'b0;
    case (mol_i)
      MOL_PROTEIN: begin
        cls_o.is_bad = !prot_ok;
      end
      MOL_DNA, MOL_RRNA: begin
        if (nucl_ok) begin
          cls_o.is_bad = 1'b0;
        end else if (ambig) begin
          cls_o.is_ambig = 1'b1;
        end else if (mol_i == MOL_DNA && base != '0) begin
          cls_o.clean_char = base;
          cls_o.is_repl    = 1'b1;
        end else begin
          cls_o.is_bad = 1'b1;
        end
      end
      default: begin
        cls_o.is_bad = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ssu_record_stats.sv
// Record counters, end-of-record status and the result register.
// Depends on ssu_pkg.
`default_nettype none

module ssu_record_stats import ssu_pkg::*; #(
  parameter int unsigned MaxRecordLen = MAX_RECORD_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  ssu_class_t        cls_i,
  input  logic              last_i,
  input  mol_e              mol_i,
  input  logic [CountW-1:0] min_len_i,
  input  logic              out_ready_i,
  output logic              take_o,
  output logic              res_valid_o,
  output ssu_result_t       res_o
);

  localparam int unsigned LenCapInt = (MaxRecordLen < 2097151) ? MaxRecordLen : 2097151;
  localparam logic [CountW-1:0] LenCap = CountW'(LenCapInt);

  logic [CountW-1:0] len_q, len_d, amb_q, amb_d, rep_q, rep_d;
  logic              bad_q, bad_d;
  logic              res_valid_q, res_valid_d;
  ssu_result_t       res_q, res_d;

  logic [CountW-1:0] len_n, amb_n, rep_n;
  logic              bad_n;
  logic [CountW+1:0] amb_x4, len_x3;
  logic [CountW+3:0] rep_x10;
  status_e           status;

  always_comb begin
    len_n = (len_q < LenCap) ? len_q + 1'b1 : len_q;
    amb_n = (cls_i.is_ambig && amb_q < LenCap) ? amb_q + 1'b1 : amb_q;
    rep_n = (cls_i.is_repl && rep_q < LenCap) ? rep_q + 1'b1 : rep_q;
    bad_n = bad_q | cls_i.is_bad;

    amb_x4  = {amb_n, 2'b00};
    len_x3  = {2'b00, len_n} + {1'b0, len_n, 1'b0};
    rep_x10 = {1'b0, rep_n, 3'b000} + {3'b000, rep_n, 1'b0};

    if (!last_i)                             status = ST_OK;
    else if (len_n < min_len_i)              status = ST_TOO_SHORT;
    else if (mol_i == MOL_UNKNOWN)           status = ST_BAD_MOL;
    else if (bad_n)                          status = ST_BAD_CHAR;
    else if (amb_x4 >= len_x3)               status = ST_MOSTLY_AMBIG;
    else if (rep_x10 > {4'b0000, len_n})     status = ST_MANY_REPL;
    else if ({amb_n, 1'b0} > {1'b0, len_n})  status = ST_HALF_AMBIG;
    else                                     status = ST_OK;
  end

  assign take_o = !res_valid_q || out_ready_i;

  always_comb begin
    len_d = len_q;
    amb_d = amb_q;
    rep_d = rep_q;
    bad_d = bad_q;
    res_d = res_q;
    if (adv_i) begin
      len_d = last_i ? '0 : len_n;
      amb_d = last_i ? '0 : amb_n;
      rep_d = last_i ? '0 : rep_n;
      bad_d = last_i ? 1'b0 : bad_n;
      res_d.clean_char      = cls_i.clean_char;
      res_d.record_end      = last_i;
      res_d.record_status   = status;
      res_d.ambiguous_count = amb_n;
      res_d.replaced_count  = rep_n;
      res_d.record_length   = len_n;
    end
    res_valid_d = adv_i || (res_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      amb_q       <= '0;
      rep_q       <= '0;
      bad_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      amb_q       <= amb_d;
      rep_q       <= rep_d;
      bad_q       <= bad_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/sequence_residue_sanitizer_unit.sv
// Sequence residue sanitizer, top level: config registers, input register, datapath.
// An input beat passes the input register, then the result register, before its result beat.
// Throughput: one character per cycle while out_o.ready stays high; with both registers full,
// in_i.ready follows out_o.ready. Reset clears config, record counters and both valid flags.
// Depends on ssu_pkg, ssu_if, ssu_classify and ssu_record_stats.
`default_nettype none

module sequence_residue_sanitizer_unit import ssu_pkg::*; #(
  parameter int unsigned MaxRecordLen = MAX_RECORD_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssu_cfg_if.sink    cfg_i,
  ssu_in_if.sink     in_i,
  ssu_out_if.source  out_o
);

  mol_e              mol_q;
  logic [CountW-1:0] min_len_q;

  logic              s1_valid_q, s1_valid_d;
  logic [CharW-1:0]  s1_char_q;
  logic              s1_last_q;

  logic              in_accept;
  logic              take;
  logic              adv;
  logic              res_valid;
  ssu_class_t        cls;
  ssu_result_t       res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mol_q     <= MOL_PROTEIN;
      min_len_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_MOLECULE:   mol_q     <= mol_e'(cfg_i.data[1:0]);
        REG_MIN_LENGTH: min_len_q <= cfg_i.data[CountW-1:0];
        default:        ;
      endcase
    end
  end

  assign adv        = s1_valid_q && take;
  assign in_i.ready = !s1_valid_q || take;
  assign in_accept  = in_i.valid && in_i.ready;
  assign s1_valid_d = in_accept || (s1_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q <= in_i.seq_char;
      s1_last_q <= in_i.last_char;
    end
  end

  ssu_classify u_classify (
    .char_i (s1_char_q),
    .mol_i  (mol_q),
    .cls_o  (cls)
  );

  ssu_record_stats #(
    .MaxRecordLen (MaxRecordLen)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cls_i       (cls),
    .last_i      (s1_last_q),
    .mol_i       (mol_q),
    .min_len_i   (min_len_q),
    .out_ready_i (out_o.ready),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_o.valid           = res_valid;
  assign out_o.clean_char      = res.clean_char;
  assign out_o.record_end      = res.record_end;
  assign out_o.record_status   = res.record_status;
  assign out_o.ambiguous_count = res.ambiguous_count;
  assign out_o.replaced_count  = res.replaced_count;
  assign out_o.record_length   = res.record_length;

endmodule

`default_nettype wire

### rtl/core/ssu_checker.sv
// Port-level checks on the result channel of the sanitizer, bound to the top level.
// Depends on ssu_pkg.
`default_nettype none

module ssu_checker import ssu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CharW-1:0]  clean_char,
  input logic              record_end,
  input logic [2:0]        record_status,
  input logic [CountW-1:0] ambiguous_count,
  input logic [CountW-1:0] replaced_count,
  input logic [CountW-1:0] record_length
);

  // status only on the closing beat of a record
  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !record_end |-> record_status == ST_OK)
    else $error("status set on a beat that does not close the record");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> record_length != '0)
    else $error("result beat with zero record length");

  a_amb_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ambiguous_count <= record_length && replaced_count <= record_length)
    else $error("count exceeds record length");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(clean_char) && $stable(record_end)
      && $stable(record_status) && $stable(record_length))
    else $error("stalled result beat changed");

endmodule

bind sequence_residue_sanitizer_unit ssu_checker u_ssu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .clean_char      (out_o.clean_char),
  .record_end      (out_o.record_end),
  .record_status   (out_o.record_status),
  .ambiguous_count (out_o.ambiguous_count),
  .replaced_count  (out_o.replaced_count),
  .record_length   (out_o.record_length)
);

`default_nettype wire

### dv/tb_sequence_residue_sanitizer_unit.sv
// Testbench of sequence_residue_sanitizer_unit: directed table, then random records under
// random source gaps and sink stalls, scored against an in-bench residue predictor.
// Depends on ssu_pkg and the ssu_if channel interfaces.
module tb_sequence_residue_sanitizer_unit;
  import ssu_pkg::*;

  localparam logic [CountW-1:0] RESIDUE_CAP =
    (MAX_RECORD_LEN < 32'h1FFFFF) ? CountW'(MAX_RECORD_LEN) : '1;
  localparam logic [CfgIdxW-1:0] REG_BEYOND = REG_MIN_LENGTH + 1'b1;
  localparam ssu_result_t NO_EXP = '0;

  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [7:0]    code;
    logic          last;
    logic [31:0]   data;
    bit            typed;
    ssu_result_t   exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssu_cfg_if cfg_bus ();
  ssu_in_if  char_bus ();
  ssu_out_if res_bus ();

  sequence_residue_sanitizer_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (char_bus),
    .out_o (res_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  mol_e              mol_kind = MOL_PROTEIN;
  logic [CountW-1:0] min_len = '0;
  logic [CountW-1:0] len_cnt = '0;
  logic [CountW-1:0] amb_cnt = '0;
  logic [CountW-1:0] rep_cnt = '0;
  bit                bad_latched = 1'b0;

  ssu_result_t pending_results [$];
  bit          row_typed = 1'b0;
  ssu_result_t row_exp = NO_EXP;
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned chars_seen = 0;
  int unsigned records_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned status_seen [7];
  int unsigned stall_left = 0;

  function automatic bit protein_residue(logic [7:0] c);
    case (c)
      "A", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M", "N", "P", "Q",
      "R", "S", "T", "U", "V", "W", "Y", "B", "X", "Z", ".", "-", "*": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit nucleotide(logic [7:0] c);
    case (c)
      "-", "A", "C", "G", "T", "U", ".": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] iupac_stand_in(logic [7:0] c);
    logic [7:0] base;
    base = 8'h00;
    if (c == "R" || c == "W" || c == "M" || c == "D" || c == "H" || c == "V") base = "A";
    if (c == "Y" || c == "B") base = "C";
    if (c == "S" || c == "K") base = "G";
    return base;
  endfunction

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] v);
    return (v < RESIDUE_CAP) ? v + 1'b1 : v;
  endfunction

  function automatic ssu_result_t sanitize_residue(logic [7:0] raw, logic last);
    ssu_result_t r;
    logic [7:0]  c;
    int unsigned l, a, p;
    c = raw;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    r = NO_EXP;
    r.clean_char = c;
    case (mol_kind)
      MOL_PROTEIN: if (!protein_residue(c)) bad_latched = 1'b1;
      MOL_DNA, MOL_RRNA: begin
        if (nucleotide(c)) begin
        end else if (c == "X" || c == "N") begin
          amb_cnt = bump(amb_cnt);
        end else if (mol_kind == MOL_DNA && iupac_stand_in(c) != 8'h00) begin
          r.clean_char = iupac_stand_in(c);
          rep_cnt = bump(rep_cnt);
        end else begin
          bad_latched = 1'b1;
        end
      end
      default: ;
    endcase
    len_cnt = bump(len_cnt);
    l = len_cnt;
    a = amb_cnt;
    p = rep_cnt;
    r.record_end = last;
    r.record_status = ST_OK;
    if (last) begin
      if (len_cnt < min_len) r.record_status = ST_TOO_SHORT;
      else if (mol_kind == MOL_UNKNOWN) r.record_status = ST_BAD_MOL;
      else if (bad_latched) r.record_status = ST_BAD_CHAR;
      else if (4 * a >= 3 * l) r.record_status = ST_MOSTLY_AMBIG;
      else if (10 * p > l) r.record_status = ST_MANY_REPL;
      else if (2 * a > l) r.record_status = ST_HALF_AMBIG;
    end
    r.ambiguous_count = amb_cnt;
    r.replaced_count = rep_cnt;
    r.record_length = len_cnt;
    if (last) begin
      len_cnt = '0;
      amb_cnt = '0;
      rep_cnt = '0;
      bad_latched = 1'b0;
    end
    return r;
  endfunction

  // input beats: predict on acceptance
  always @(posedge clk_i) begin
    ssu_result_t predicted;
    if (rst_ni && char_bus.valid && char_bus.ready) begin
      predicted = sanitize_residue(char_bus.seq_char, char_bus.last_char);
      pending_results.push_back(row_typed ? row_exp : predicted);
      chars_seen++;
    end
  end

  // result beats: compare with oldest expectation
  always @(posedge clk_i) begin
    ssu_result_t e;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (res_bus.clean_char !== e.clean_char) begin
          $error("clean_char exp %0h got %0h", e.clean_char, res_bus.clean_char);
          mismatches++;
        end
        if (res_bus.record_end !== e.record_end) begin
          $error("record_end exp %0d got %0d", e.record_end, res_bus.record_end);
          mismatches++;
        end
        if (res_bus.record_status !== e.record_status) begin
          $error("record_status exp %0d got %0d", e.record_status, res_bus.record_status);
          mismatches++;
        end
        if (res_bus.ambiguous_count !== e.ambiguous_count) begin
          $error("ambiguous_count exp %0d got %0d", e.ambiguous_count,
                 res_bus.ambiguous_count);
          mismatches++;
        end
        if (res_bus.replaced_count !== e.replaced_count) begin
          $error("replaced_count exp %0d got %0d", e.replaced_count, res_bus.replaced_count);
          mismatches++;
        end
        if (res_bus.record_length !== e.record_length) begin
          $error("record_length exp %0d got %0d", e.record_length, res_bus.record_length);
          mismatches++;
        end
        if (e.record_end) begin
          records_seen++;
          if (e.record_status <= ST_TOO_SHORT) status_seen[e.record_status]++;
        end
      end
    end
  end

  // sink stalls
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  task automatic push_char(logic [7:0] c, logic last, bit typed, ssu_result_t exp);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_typed = typed;
    row_exp = exp;
    char_bus.valid <= 1'b1;
    char_bus.seq_char <= c;
    char_bus.last_char <= last;
    do @(posedge clk_i); while (!char_bus.ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    char_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == REG_MOLECULE) mol_kind = mol_e'(data[1:0]);
    else if (idx == REG_MIN_LENGTH) min_len = data[CountW-1:0];
    reg_writes++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_residue(int unsigned flavor);
    string      pool;
    logic [7:0] c;
    case (flavor)
      0: pool = "NXnxNXACGT";
      1: pool = "ACGTURYSWKMBDHV-.";
      default: pool = "ACDEFGHIKLMNPQRSTUVWYBXZ.-*JO";
    endcase
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    c = pool[$urandom_range(0, pool.len() - 1)];
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'd32;
    return c;
  endfunction

  initial begin
    row_t        plan [$];
    int unsigned phase, rec, k, rec_len, flavor, pick;
    logic [CfgDataW-1:0] min_data;

    char_bus.valid = 1'b0;
    char_bus.seq_char = '0;
    char_bus.last_char = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;

    plan = '{
      '{ROW_CHAR, "x",   1'b1, 32'd0, 1'b1, '{"X",   1'b1, ST_OK,       21'd0, 21'd0, 21'd1}},
      '{ROW_CHAR, 8'h00, 1'b1, 32'd0, 1'b1, '{8'h00, 1'b1, ST_BAD_CHAR, 21'd0, 21'd0, 21'd1}},
      '{ROW_CHAR, 8'hFF, 1'b1, 32'd0, 1'b1, '{8'hFF, 1'b1, ST_BAD_CHAR, 21'd0, 21'd0, 21'd1}},
      '{ROW_REG,  REG_MOLECULE, 1'b0, 32'(MOL_DNA), 1'b0, NO_EXP},
      '{ROW_CHAR, "r",   1'b1, 32'd0, 1'b1, '{"A", 1'b1, ST_MANY_REPL, 21'd0, 21'd1, 21'd1}},
      '{ROW_CHAR, "n",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "x",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "a",   1'b1, 32'd0, 1'b1, '{"A", 1'b1, ST_HALF_AMBIG, 21'd2, 21'd0, 21'd3}},
      '{ROW_CHAR, "N",   1'b1, 32'd0, 1'b1, '{"N", 1'b1, ST_MOSTLY_AMBIG, 21'd1, 21'd0, 21'd1}},
      '{ROW_CHAR, "y",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "s",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "k",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "w",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "m",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "b",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "d",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "h",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "v",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "-",   1'b1, 32'd0, 1'b1, '{"-", 1'b1, ST_MANY_REPL, 21'd0, 21'd9, 21'd10}},
      '{ROW_REG,  REG_MOLECULE, 1'b0, 32'(MOL_RRNA), 1'b0, NO_EXP},
      '{ROW_CHAR, "r",   1'b1, 32'd0, 1'b1, '{"R", 1'b1, ST_BAD_CHAR, 21'd0, 21'd0, 21'd1}},
      '{ROW_CHAR, "u",   1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, ".",   1'b1, 32'd0, 1'b1, '{".", 1'b1, ST_OK, 21'd0, 21'd0, 21'd2}},
      '{ROW_REG,  REG_MOLECULE, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_EXP},
      '{ROW_CHAR, "q",   1'b1, 32'd0, 1'b1, '{"Q", 1'b1, ST_BAD_MOL, 21'd0, 21'd0, 21'd1}},
      '{ROW_REG,  REG_MIN_LENGTH, 1'b0, 32'd2, 1'b0, NO_EXP},
      '{ROW_CHAR, "A",   1'b1, 32'd0, 1'b1, '{"A", 1'b1, ST_TOO_SHORT, 21'd0, 21'd0, 21'd1}},
      '{ROW_REG,  REG_MIN_LENGTH, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_EXP},
      '{ROW_CHAR, "C",   1'b1, 32'd0, 1'b1, '{"C", 1'b1, ST_TOO_SHORT, 21'd0, 21'd0, 21'd1}},
      '{ROW_REG,  REG_BEYOND, 1'b0, 32'd0, 1'b0, NO_EXP},
      '{ROW_CHAR, "G",   1'b1, 32'd0, 1'b1, '{"G", 1'b1, ST_TOO_SHORT, 21'd0, 21'd0, 21'd1}},
      '{ROW_REG,  REG_MIN_LENGTH, 1'b0, 32'd0, 1'b0, NO_EXP}
    };

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].code, plan[i].data);
      else push_char(plan[i].code, plan[i].last, plan[i].typed, plan[i].exp);
    end

    // random records, one setting of both registers per phase
    phase = 0;
    while (chars_seen < 1180) begin
      write_reg(REG_MOLECULE, $urandom());
      pick = $urandom_range(0, 9);
      if (pick == 0) min_data = MAX_RECORD_LEN;
      else if (pick == 1) min_data = $urandom();
      else min_data = $urandom_range(0, 6);
      write_reg(REG_MIN_LENGTH, min_data);
      for (rec = 0; rec < 10; rec++) begin
        rec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 16);
        flavor = $urandom_range(0, 3);
        for (k = 0; k < rec_len; k++) begin
          if (phase == 2 && rec == 2 && k == 1) drain_results();
          calm = (chars_seen > 1100);
          push_char(pick_residue(flavor), k == rec_len - 1, 1'b0, NO_EXP);
        end
      end
      phase++;
    end

    drain_results();
    repeat (10) @(negedge clk_i);
    $display("checked %0d characters in %0d records over %0d register writes",
             chars_seen, records_seen, reg_writes);
    $display("record statuses ok/half/repl/mostly/bad/mol/short: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
